/* hw/rtl/sha256_pkg.sv */
// SHA-256 package: sequencer states, round constants, initial hash values
// and the round/schedule functions. Used by sha256_message_digest_unit.
// No dependencies.
package sha256_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumWords  = 8;
  localparam int unsigned WinWords  = 16;
  localparam int unsigned CountW    = 61;
  localparam int unsigned LenField  = 56;
  localparam logic [7:0]  PadMarker = 8'h80;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } sha_state_e;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t sml_sig0(input word_t x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t initial_hash(input logic [2:0] idx);
    unique case (idx)
      3'd0: initial_hash = 32'h6a09e667;
      3'd1: initial_hash = 32'hbb67ae85;
      3'd2: initial_hash = 32'h3c6ef372;
      3'd3: initial_hash = 32'ha54ff53a;
      3'd4: initial_hash = 32'h510e527f;
      3'd5: initial_hash = 32'h9b05688c;
      3'd6: initial_hash = 32'h1f83d9ab;
      default: initial_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    unique case (t)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

/* hw/rtl/sha256_message_digest_unit.sv */
// SHA-256 digest unit: byte absorb, padding sequencer, one-round-per-cycle
// compression core and digest word output.
// Depends on sha256_pkg.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | to unit   | in_valid_i / in_stall_o   | data_byte, has_byte, end_of_msg
//   out     | from unit | out_valid_o / out_stall_i | digest_word, word_index, last
//
// The 64th byte of a block starts a compression: 64 rounds through the
// shared round unit plus one feed-forward step, with the input stalled
// throughout. A final beat inserts padding one byte per cycle, runs one or
// two compressions, then emits eight output beats. No clearing pass after
// reset.
module sha256_message_digest_unit
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha_state_e state_q, state_d;

  logic [NumWords-1:0][WordW-1:0] hash_q;
  logic [NumWords-1:0][WordW-1:0] work_q;   // index 0 is a, 7 is h
  logic [WinWords-1:0][WordW-1:0] win_q;    // index 15 is the oldest word
  logic [CountW-1:0]              count_q;
  logic [5:0]                     fill_q;
  logic [5:0]                     round_q;
  logic [2:0]                     idx_q;
  logic                           pad_q, first_q, zf_q, final_q;

  logic       in_acc, out_acc;
  logic       wr_en;
  logic [7:0] wr_byte;
  logic       blk_full;
  logic       is_zf;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  word_t      w_new, t1, t2, w_cur;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  // length field bytes go out most significant first
  assign len_bits = {count_q, 3'b000};
  assign len_byte = 8'(len_bits >> {~fill_q[2:0], 3'b000});

  // true when this padding block only gets zero fill, length goes next block
  assign is_zf = first_q ? (fill_q >= 6'(LenField)) : zf_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = data_byte_i;
    if (state_q == ST_IDLE) begin
      wr_en = in_acc & has_byte_i;
    end else if (state_q == ST_PAD) begin
      wr_en = 1'b1;
      if (first_q) begin
        wr_byte = PadMarker;
      end else if (!zf_q && fill_q >= 6'(LenField)) begin
        wr_byte = len_byte;
      end else begin
        wr_byte = 8'h00;
      end
    end
  end

  assign blk_full = wr_en & (fill_q == 6'd63);

  // round unit
  assign w_cur = win_q[15];
  assign w_new = sml_sig1(win_q[1]) + win_q[6] + sml_sig0(win_q[14]) + win_q[15];
  assign t1 = work_q[7] + big_sig1(work_q[4])
            + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
            + round_k(round_q) + w_cur;
  assign t2 = big_sig0(work_q[0])
            + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (blk_full) begin
          state_d = ST_ROUND;
        end else if (in_acc && end_of_message_i) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (blk_full) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_q == 6'd63) state_d = ST_FEED;
      end
      ST_FEED: begin
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (final_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc && idx_q == 3'd7) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_o   = (state_q == ST_OUT);
    digest_word_o = hash_q[idx_q];
    word_index_o  = idx_q;
    last_word_o   = (idx_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      fill_q  <= '0;
      round_q <= '0;
      idx_q   <= '0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      zf_q    <= 1'b0;
      final_q <= 1'b0;
      for (int i = 0; i < NumWords; i++) hash_q[i] <= initial_hash(3'(i));
    end else begin
      state_q <= state_d;
      if (wr_en) fill_q <= fill_q + 6'd1;
      if (blk_full) round_q <= '0;
      else if (state_q == ST_ROUND) round_q <= round_q + 6'd1;

      if (state_q == ST_IDLE && in_acc) begin
        if (has_byte_i) count_q <= count_q + CountW'(1);
        if (end_of_message_i) begin
          pad_q   <= 1'b1;
          first_q <= 1'b1;
          zf_q    <= 1'b0;
          final_q <= 1'b0;
        end
      end

      if (state_q == ST_PAD) begin
        first_q <= 1'b0;
        if (fill_q == 6'd63) begin
          zf_q    <= 1'b0;
          final_q <= ~is_zf;
        end else begin
          zf_q <= is_zf;
        end
      end

      if (state_q == ST_FEED) begin
        for (int i = 0; i < NumWords; i++) hash_q[i] <= hash_q[i] + work_q[i];
      end

      if (out_acc) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          count_q <= '0;
          pad_q   <= 1'b0;
          final_q <= 1'b0;
          for (int i = 0; i < NumWords; i++) hash_q[i] <= initial_hash(3'(i));
        end
      end
    end
  end

  // payload: window and working variables
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_q <= (WinWords*WordW)'({win_q, wr_byte});
    end else if (state_q == ST_ROUND) begin
      win_q <= {win_q[14:0], w_new};
    end
    if (blk_full) begin
      work_q <= hash_q;
    end else if (state_q == ST_ROUND) begin
      work_q <= {work_q[6:4], work_q[3] + t1, work_q[2:0], t1 + t2};
    end
  end

endmodule

/* sim/sha256_digest_checker.sv */
// Watches both channels of sha256_message_digest_unit, predicts the digest
// words of every message and compares them beat by beat.
// Depends on sha256_pkg for the word type only.
`timescale 1ns / 1ps

module sha256_digest_checker
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_OFFSET = 56;

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_beat_t;

  word_t        chain_h [8];
  logic [7:0]   msg_block [64];
  logic [60:0]  byte_count;
  digest_beat_t digest_q [$];
  digest_beat_t want;

  function automatic word_t ror(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    word_t w [16];
    word_t v [8];
    word_t wt, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        // rolling 16-word schedule window
        s0 = ror(w[(t-15) & 15], 7) ^ ror(w[(t-15) & 15], 18) ^ (w[(t-15) & 15] >> 3);
        s1 = ror(w[(t-2) & 15], 17) ^ ror(w[(t-2) & 15], 19) ^ (w[(t-2) & 15] >> 10);
        wt = s1 + w[(t-7) & 15] + s0 + w[t & 15];
        w[t & 15] = wt;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  task automatic absorb_beat(input logic [7:0] data, input logic has_byte, input logic eom);
    int unsigned  fill;
    logic [63:0]  bit_len;
    digest_beat_t beat;
    if (has_byte) begin
      fill = byte_count[5:0];
      msg_block[fill] = data;
      byte_count = byte_count + 61'd1;
      if (fill == 63) compress_block();
    end
    if (eom) begin
      fill = byte_count[5:0];
      msg_block[fill] = PAD_BYTE;
      fill++;
      // no room left for the length: spill into a second block
      if (fill > LEN_OFFSET) begin
        for (int i = fill; i < 64; i++) msg_block[i] = 8'h00;
        compress_block();
        fill = 0;
      end
      for (int i = fill; i < LEN_OFFSET; i++) msg_block[i] = 8'h00;
      bit_len = {byte_count, 3'b000};
      for (int i = 0; i < 8; i++) msg_block[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        beat.word = chain_h[i];
        beat.idx  = 3'(i);
        beat.last = (i == 7);
        digest_q.insert(digest_q.size(), beat);
      end
      for (int i = 0; i < 8; i++) chain_h[i] = SHA_H0[i];
      byte_count = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain_h[i] = SHA_H0[i];
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      byte_count = '0;
      digest_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        absorb_beat(data_byte_i, has_byte_i, end_of_message_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("digest beat with nothing pending: digest_word %h word_index %0d",
                 digest_word_i, word_index_i);
          fail_count_o++;
        end else begin
          want = digest_q.pop_front();
          if (digest_word_i !== want.word) begin
            $error("digest_word expected %h actual %h", want.word, digest_word_i);
            fail_count_o++;
          end
          if (word_index_i !== want.idx) begin
            $error("word_index expected %0d actual %0d", want.idx, word_index_i);
            fail_count_o++;
          end
          if (last_word_i !== want.last) begin
            $error("last_word expected %b actual %b", want.last, last_word_i);
            fail_count_o++;
          end
        end
      end
      pending_o = digest_q.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// Top of the SHA-256 digest unit testbench: clock, reset, byte stimulus and
// output backpressure. Depends on sha256_message_digest_unit and
// sha256_digest_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_ITEMS   = 410;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_WAIT  = 250;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte  = 8'h00;
  logic        has_byte   = 1'b0;
  logic        eom        = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending;
  int unsigned msg_items  = 0;
  int unsigned idle_cycles = 0;
  bit          tx_burst   = 1'b0;

  sha256_message_digest_unit DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .has_byte_i       (has_byte),
    .end_of_message_i (eom),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .digest_word_o    (digest_word),
    .word_index_o     (word_index),
    .last_word_o      (last_word)
  );

  sha256_digest_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .has_byte_i       (has_byte),
    .end_of_message_i (eom),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .digest_word_i    (digest_word),
    .word_index_i     (word_index),
    .last_word_i      (last_word),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $error("no beat for %0d cycles, %0d digest words pending", IDLE_LIMIT, pending);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // one input beat; valid stays high across back-to-back beats
  task automatic push_beat(input logic [7:0] b, input logic hb, input logic last);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= hb;
    eom       <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    msg_items++;
    @(negedge clk);
  endtask

  // len random bytes, with an occasional idle beat mixed in; the final beat
  // either carries the last byte or is empty
  task automatic send_message(input int unsigned len, input bit byte_on_final);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 11) == 0) push_beat(8'($urandom), 1'b0, 1'b0);
      push_beat(8'($urandom), 1'b1, byte_on_final && (k == len - 1));
    end
    if (!byte_on_final || len == 0) push_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // output side: random stalls, one long hold-off early on
  initial begin : drain
    int unsigned gap;
    int unsigned beats;
    bit          rx_burst;
    beats = 0;
    rx_burst = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 13);
      if (beats == 16) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned len;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty message, then idle beats that must change nothing
    send_message(0, 1'b0);
    push_beat(8'hff, 1'b0, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    // "abc" with the last byte on the final beat
    push_beat(8'h61, 1'b1, 1'b0);
    push_beat(8'h62, 1'b1, 1'b0);
    push_beat(8'h63, 1'b1, 1'b1);
    // byte extremes, closed by an empty final beat whose data is ignored
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'hff, 1'b1, 1'b0);
    push_beat(8'hff, 1'b0, 1'b0);
    push_beat(8'hff, 1'b0, 1'b1);
    // single byte 0xff as the final beat
    push_beat(8'hff, 1'b1, 1'b1);

    // lengths cluster around the one/two padding block boundary
    while (msg_items < NUM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      len = $urandom_range(0, 8);
      else if (pick < 8) len = $urandom_range(52, 72);
      else               len = $urandom_range(0, 140);
      // keep the total beat count close to the target
      if (len > NUM_ITEMS - msg_items) len = NUM_ITEMS - msg_items;
      send_message(len, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
